[design/wcts_pkg.sv]
// ----------------------------------------------------------------------------
// Weighted category table sampler package
// Shared constants, command and status codes, the queue entry type and the engine state type.
// ----------------------------------------------------------------------------
package wcts_pkg;

  localparam int MAX_CATEGORIES = 16;
  localparam int IDX_W = $clog2(MAX_CATEGORIES);
  localparam int CNT_W = $clog2(MAX_CATEGORIES + 1);

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [20:0] SUM_LIMIT = 21'd1048576;
  localparam logic [31:0] MINUS_ONE_Q16 = 32'hFFFF0000;

  typedef enum logic [2:0] {
    CMD_SET    = 3'd0,
    CMD_ADD    = 3'd1,
    CMD_READ   = 3'd2,
    CMD_QUERY  = 3'd3,
    CMD_SAMPLE = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_RANGE     = 3'd3,
    ST_NO_SAMPLE = 3'd4
  } status_t;

  // One decoded transaction handed from the front to the back.
  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] value;
    logic [16:0] weight;
    logic [3:0]  index;
    logic [16:0] draw;
  } job_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

endpackage

[design/wcts_front.sv]
// ----------------------------------------------------------------------------
// Front end
// Accepts transactions, clamps the weight and queues them for the back end.
// ----------------------------------------------------------------------------
module wcts_front
  import wcts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        valid_in,
  output logic        stall_in,
  input  logic [2:0]  command,
  input  logic [31:0] category_value,
  input  logic [16:0] weight_in,
  input  logic [3:0]  entry_index,
  input  logic [16:0] random_draw,
  output logic        job_valid,
  input  logic        job_take,
  output job_t        job
);

  job_t       q [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;
  logic       push, pop;

  // The queue holds two transactions.
  assign stall_in  = (fill == 2'd2);
  assign push      = valid_in && !stall_in;
  assign job_valid = (fill != 2'd0);
  assign pop       = job_valid && job_take;
  assign job       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr].command <= command;
      q[wr_ptr].value   <= category_value;
      q[wr_ptr].weight  <= (weight_in > ONE_Q16) ? ONE_Q16 : weight_in;
      q[wr_ptr].index   <= entry_index;
      q[wr_ptr].draw    <= random_draw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[design/wcts_back.sv]
// ----------------------------------------------------------------------------
// Back end
// Walks the sorted table one entry per cycle and forms the result.
// ----------------------------------------------------------------------------
module wcts_back
  import wcts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  output logic        job_take,
  input  job_t        job,
  output logic        valid_out,
  input  logic        stall_out,
  output logic [2:0]  status,
  output logic [31:0] category_out,
  output logic [16:0] weight_out,
  output logic [20:0] sum_below,
  output logic [20:0] sum_above,
  output logic [20:0] at_or_below,
  output logic [20:0] at_or_above,
  output logic [4:0]  entry_count
);

  logic [31:0] keys [MAX_CATEGORIES];
  logic [16:0] wts  [MAX_CATEGORIES];
  logic [CNT_W-1:0] used;

  state_t state, state_next;
  job_t   cur;
  logic [CNT_W-1:0] ptr;
  logic [20:0] lo, hi;
  logic [21:0] run;
  logic hit, found, full_miss;
  logic [IDX_W-1:0] pos;

  logic [IDX_W-1:0] pi;
  logic [31:0] k;
  logic [16:0] w;
  logic scan_end, keq, kgt;
  logic lands, key_hit, room, grow;
  logic [21:0] run_sum;
  logic [17:0] add_sum;

  assign pi       = ptr[IDX_W-1:0];
  assign k        = keys[pi];
  assign w        = wts[pi];
  assign scan_end = (ptr >= used);
  assign keq      = ($signed(k) == $signed(cur.value));
  assign kgt      = ($signed(k) > $signed(cur.value));
  assign run_sum  = run + {5'd0, w};
  assign add_sum  = {1'b0, wts[pos]} + {1'b0, cur.weight};

  // Set and add stop at the first key not below the value; a new key needs room.
  assign lands    = scan_end || keq || kgt;
  assign key_hit  = !scan_end && keq;
  assign room     = (used != MAX_CATEGORIES[CNT_W-1:0]);
  assign grow     = !key_hit && room;

  function automatic logic [20:0] sat_add(logic [20:0] a, logic [16:0] b);
    logic [21:0] s;
    s = {1'b0, a} + {5'd0, b};
    return (s > {1'b0, SUM_LIMIT}) ? SUM_LIMIT : s[20:0];
  endfunction

  assign job_take = (state == S_IDLE) && !valid_out;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (job_valid && !valid_out) state_next = S_SCAN;
      S_SCAN: begin
        unique case (cur.command)
          CMD_SET, CMD_ADD: begin
            if (lands) state_next = grow ? S_SHIFT : S_DONE;
          end
          CMD_QUERY: if (scan_end) state_next = S_DONE;
          CMD_SAMPLE: begin
            if (scan_end || {5'd0, cur.draw} <= run_sum) state_next = S_DONE;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_SHIFT: if (ptr == {1'b0, pos}) state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath and table update.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      valid_out <= 1'b0;
    end else begin
      state <= state_next;
      if (valid_out && !stall_out) valid_out <= 1'b0;
      unique case (state)
        S_IDLE: if (job_valid && !valid_out) begin
          cur <= job;
          ptr <= '0;
          lo <= '0; hi <= '0; run <= '0;
          hit <= 1'b0; found <= 1'b0; full_miss <= 1'b0;
        end
        S_SCAN: begin
          unique case (cur.command)
            CMD_SET, CMD_ADD: begin
              if (lands) begin
                pos       <= pi;
                hit       <= key_hit;
                full_miss <= !key_hit && !room;
                // Open a slot by shifting from the top down.
                if (grow) ptr <= used;
              end else ptr <= ptr + CNT_W'(1);
            end
            CMD_QUERY: begin
              if (!scan_end) begin
                if (found) hi <= sat_add(hi, w);
                else if (keq) begin
                  found <= 1'b1; pos <= pi;
                end else lo <= sat_add(lo, w);
                ptr <= ptr + CNT_W'(1);
              end
            end
            CMD_SAMPLE: begin
              if (!scan_end) begin
                run <= run_sum;
                if ({5'd0, cur.draw} <= run_sum) begin
                  found <= 1'b1; pos <= pi;
                end else ptr <= ptr + CNT_W'(1);
              end
            end
            default: ;
          endcase
        end
        S_SHIFT: begin
          if (ptr == {1'b0, pos}) begin
            keys[pi] <= cur.value;
            wts[pi]  <= cur.weight;
            used     <= used + CNT_W'(1);
          end else begin
            keys[pi] <= keys[pi - IDX_W'(1)];
            wts[pi]  <= wts[pi - IDX_W'(1)];
            ptr      <= ptr - CNT_W'(1);
          end
        end
        S_DONE: begin
          valid_out    <= 1'b1;
          status       <= ST_OK;
          category_out <= '0;
          weight_out   <= '0;
          sum_below    <= '0;
          sum_above    <= '0;
          at_or_below  <= '0;
          at_or_above  <= '0;
          entry_count  <= 5'(used);
          unique case (cur.command)
            CMD_SET, CMD_ADD: begin
              if (hit) begin
                category_out <= cur.value;
                if (cur.command == CMD_SET) begin
                  wts[pos] <= cur.weight; weight_out <= cur.weight;
                end else begin
                  wts[pos] <= (add_sum > {1'b0, ONE_Q16}) ? ONE_Q16 : add_sum[16:0];
                  weight_out <= (add_sum > {1'b0, ONE_Q16}) ? ONE_Q16 : add_sum[16:0];
                end
              end else if (full_miss) begin
                status <= ST_FULL;
              end else begin
                category_out <= cur.value;
                weight_out   <= cur.weight;
              end
            end
            CMD_READ: begin
              if ({1'b0, cur.index} >= 5'(used)) status <= ST_RANGE;
              else begin
                category_out <= keys[cur.index[IDX_W-1:0]];
                weight_out   <= wts[cur.index[IDX_W-1:0]];
              end
            end
            CMD_QUERY: begin
              sum_below <= lo;
              at_or_above <= 21'({4'd0, ONE_Q16}) - lo;
              if (found) begin
                category_out <= cur.value;
                weight_out   <= wts[pos];
                sum_above    <= hi;
                at_or_below  <= 21'({4'd0, ONE_Q16}) - hi;
              end else status <= ST_NOT_FOUND;
            end
            CMD_SAMPLE: begin
              if (found) begin
                category_out <= keys[pos];
                weight_out   <= wts[pos];
              end else begin
                status       <= ST_NO_SAMPLE;
                category_out <= MINUS_ONE_Q16;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

endmodule

[design/weighted_category_table_sampler.sv]
// ----------------------------------------------------------------------------
// Weighted category table sampler
// Sorted table of up to sixteen weighted categories with set, add, read,
// query and sampling commands.
// ----------------------------------------------------------------------------
// Usage: the input channel (valid_in, stall_in) carries one command per
// transaction; the output channel (valid_out, stall_out) returns exactly one
// result per command, in order. A two-entry queue separates the front from
// the table engine, so commands are taken while a result waits.
// Read and unknown codes do not walk the table. Other commands walk the table
// one entry per cycle; an insert that stops early then moves the entries above
// its slot up to open it. The engine takes a new command only once it has
// finished the last one and that result has been taken; the walk sets the pace.
// Reset empties the table and drops any queued transactions.
// A stalled result holds; the engine waits until it is taken.
// ----------------------------------------------------------------------------
module weighted_category_table_sampler
  import wcts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        valid_in,
  output logic        stall_in,
  input  logic [2:0]  command,
  input  logic [31:0] category_value,
  input  logic [16:0] weight_in,
  input  logic [3:0]  entry_index,
  input  logic [16:0] random_draw,
  output logic        valid_out,
  input  logic        stall_out,
  output logic [2:0]  status,
  output logic [31:0] category_out,
  output logic [16:0] weight_out,
  output logic [20:0] sum_below,
  output logic [20:0] sum_above,
  output logic [20:0] at_or_below,
  output logic [20:0] at_or_above,
  output logic [4:0]  entry_count
);

  logic job_valid, job_take;
  job_t job;

  wcts_front u_front (
    .clk, .rst, .valid_in, .stall_in, .command, .category_value,
    .weight_in, .entry_index, .random_draw, .job_valid, .job_take, .job
  );

  wcts_back u_back (
    .clk, .rst, .job_valid, .job_take, .job, .valid_out, .stall_out,
    .status, .category_out, .weight_out, .sum_below, .sum_above,
    .at_or_below, .at_or_above, .entry_count
  );

endmodule
